// File: src/esc_tpr_pkg.sv
// Shared types, constants and register map for the ESC throttle pulse ramp.
`default_nettype none

package esc_tpr_pkg;

   // Default sizes handed to the top level parameters
   localparam int PULSE_BITS_DEF = 12;
   localparam int COUNT_BITS_DEF = 16;

   // Width of the goal sum before saturation (12-bit neutral + 11-bit offset, up to 16-bit max)
   localparam int SUM_BITS = 17;

   // Register reset values
   localparam logic [11:0] NEUTRAL_RESET    = 12'd1500;
   localparam logic [10:0] MAX_OFFSET_RESET = 11'd450;
   localparam logic [7:0]  STEP_RESET       = 8'd2;
   localparam logic [7:0]  DELAY_RESET      = 8'd5;
   localparam logic [15:0] PAUSE_RESET      = 16'd500;
   localparam logic [15:0] ARM_RESET        = 16'd5000;

   // Speed scaling: full speed in percent, and divide-by-100 reciprocal (2^19 / 100, rounded up)
   localparam logic [6:0]  FULL_PCT    = 7'd100;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_NEUTRAL    = 3'd0;
   localparam logic [2:0] REG_MAX_OFFSET = 3'd1;
   localparam logic [2:0] REG_STEP       = 3'd2;
   localparam logic [2:0] REG_DELAY      = 3'd3;
   localparam logic [2:0] REG_PAUSE      = 3'd4;
   localparam logic [2:0] REG_ARM        = 3'd5;

   // Command codes of an input word
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_ARM      = 2'd1,
      CMD_THROTTLE = 2'd2
   } cmd_type;

   // Controller phase, also reported on the result channel
   typedef enum logic [2:0] {
      PH_UNARMED    = 3'd0,
      PH_ARMING     = 3'd1,
      PH_HOLDING    = 3'd2,
      PH_TO_NEUTRAL = 3'd3,
      PH_PAUSING    = 3'd4,
      PH_TO_TARGET  = 3'd5
   } phase_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [11:0] neutral_us;
      logic [10:0] max_offset_us;
      logic [7:0]  step_us;
      logic [7:0]  delay_ticks;
      logic [15:0] pause_ticks;
      logic [15:0] arm_ticks;
   } cfg_type;

endpackage

`default_nettype wire

// File: src/esc_tpr_csr.sv
// APB-style configuration register file for the ESC throttle pulse ramp.
`default_nettype none

module esc_tpr_csr
   import esc_tpr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [2:0]  reg_idx;
   logic        wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_NEUTRAL:    cfg_in.neutral_us    = pwdata[11:0];
            REG_MAX_OFFSET: cfg_in.max_offset_us = pwdata[10:0];
            REG_STEP:       cfg_in.step_us       = pwdata[7:0];
            REG_DELAY:      cfg_in.delay_ticks   = pwdata[7:0];
            REG_PAUSE:      cfg_in.pause_ticks   = pwdata[15:0];
            REG_ARM:        cfg_in.arm_ticks     = pwdata[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neutral_us    <= NEUTRAL_RESET;
         cfg_ff.max_offset_us <= MAX_OFFSET_RESET;
         cfg_ff.step_us       <= STEP_RESET;
         cfg_ff.delay_ticks   <= DELAY_RESET;
         cfg_ff.pause_ticks   <= PAUSE_RESET;
         cfg_ff.arm_ticks     <= ARM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_NEUTRAL:    prdata = {20'd0, cfg_ff.neutral_us};
         REG_MAX_OFFSET: prdata = {21'd0, cfg_ff.max_offset_us};
         REG_STEP:       prdata = {24'd0, cfg_ff.step_us};
         REG_DELAY:      prdata = {24'd0, cfg_ff.delay_ticks};
         REG_PAUSE:      prdata = {16'd0, cfg_ff.pause_ticks};
         REG_ARM:        prdata = {16'd0, cfg_ff.arm_ticks};
         default:        prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// File: src/esc_tpr_tgt.sv
// Goal pulse pipeline: input register, offset multiply, divide by 100, goal saturation.
`default_nettype none

module esc_tpr_tgt
   import esc_tpr_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   input  wire logic signed [1:0]     req_direction,
   input  wire logic [7:0]            req_speed_pct,
   output logic                       item_valid,
   input  wire logic                  item_ready,
   output logic [1:0]                 item_cmd,
   output logic [PULSE_BITS-1:0]      item_tgt
);

   // Stage valids and advance conditions
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   // Stage 1: input word
   logic [1:0]  cmd1_ff;
   logic [1:0]  dir1_ff;
   logic [7:0]  spd1_ff;

   // Stage 2: offset product and direction flags
   logic [1:0]  cmd2_ff;
   logic        plus2_ff, minus2_ff;
   logic [17:0] prod2_ff;
   logic [6:0]  spd_cl;
   logic [17:0] prod_in;

   // Stage 3: quotient estimate
   logic [1:0]  cmd3_ff;
   logic        plus3_ff, minus3_ff;
   logic [17:0] prod3_ff;
   logic [11:0] quo3_ff;
   logic [30:0] recip_prod;

   // Stage 4: goal pulse
   logic [1:0]            cmd4_ff;
   logic [PULSE_BITS-1:0] tgt4_ff;
   logic [PULSE_BITS-1:0] tgt_in;
   logic [18:0]           quo_x100;
   logic [11:0]           off12;
   logic [10:0]           off;
   logic [SUM_BITS-1:0]   sum_up;
   logic [SUM_BITS-1:0]   pulse_max;
   logic [SUM_BITS-1:0]   sum_sat;
   logic [11:0]           diff_dn;

   // Ready chain: a stage loads when it is empty or its contents move on
   assign rdy4      = !v4_ff || item_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Speed clamp and offset multiply
   assign spd_cl  = (spd1_ff > 8'(FULL_PCT)) ? FULL_PCT : spd1_ff[6:0];
   assign prod_in = 18'(cfg.max_offset_us) * 18'(spd_cl);

   // Divide by 100: reciprocal multiply, never below the true quotient
   assign recip_prod = 31'(prod2_ff) * 31'(RECIP_100);

   // Correct the estimate by one where it overshoots, then form the goal
   assign quo_x100  = 19'(quo3_ff) * 19'(FULL_PCT);
   assign off12     = (quo_x100 > 19'(prod3_ff)) ? (quo3_ff - 12'd1) : quo3_ff;
   assign off       = off12[10:0];
   assign sum_up    = SUM_BITS'(cfg.neutral_us) + SUM_BITS'(off);
   assign pulse_max = {{(SUM_BITS-PULSE_BITS){1'b0}}, {PULSE_BITS{1'b1}}};
   assign sum_sat   = (sum_up > pulse_max) ? pulse_max : sum_up;
   assign diff_dn   = (12'(off) > cfg.neutral_us) ? 12'd0 : (cfg.neutral_us - 12'(off));

   always_comb begin
      if (plus3_ff) begin
         tgt_in = sum_sat[PULSE_BITS-1:0];
      end else if (minus3_ff) begin
         tgt_in = PULSE_BITS'(diff_dn);
      end else begin
         tgt_in = PULSE_BITS'(cfg.neutral_us);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (rdy1) begin
         cmd1_ff <= req_command;
         dir1_ff <= req_direction;
         spd1_ff <= req_speed_pct;
      end
      if (rdy2) begin
         cmd2_ff   <= cmd1_ff;
         plus2_ff  <= (dir1_ff == 2'b01) && (spd1_ff != 8'd0);
         minus2_ff <= dir1_ff[1] && (spd1_ff != 8'd0);
         prod2_ff  <= prod_in;
      end
      if (rdy3) begin
         cmd3_ff   <= cmd2_ff;
         plus3_ff  <= plus2_ff;
         minus3_ff <= minus2_ff;
         prod3_ff  <= prod2_ff;
         quo3_ff   <= recip_prod[RECIP_SHIFT+11:RECIP_SHIFT];
      end
      if (rdy4) begin
         cmd4_ff <= cmd3_ff;
         tgt4_ff <= tgt_in;
      end
   end

   assign item_valid = v4_ff;
   assign item_cmd   = cmd4_ff;
   assign item_tgt   = tgt4_ff;

endmodule

`default_nettype wire

// File: src/esc_tpr_core.sv
// Arming, ramp and pause controller with the result register.
`default_nettype none

module esc_tpr_core
   import esc_tpr_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  item_valid,
   output logic                       item_ready,
   input  wire logic [1:0]            item_cmd,
   input  wire logic [PULSE_BITS-1:0] item_tgt,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PULSE_BITS-1:0]      rsp_pulse_us,
   output logic [2:0]                 rsp_phase,
   output logic                       rsp_accepted
);

   // Compare width for the wait counter against 8- and 16-bit limits
   localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [PULSE_BITS-1:0] pulse_ff, pulse_in;
   logic [PULSE_BITS-1:0] goal_ff, goal_in;
   phase_type             mode_ff, mode_in;
   logic [COUNT_BITS-1:0] wait_ff, wait_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PULSE_BITS-1:0] rsp_pulse_ff;
   phase_type             rsp_phase_ff;
   logic                  rsp_acc_ff;

   logic                  take;
   logic                  took;
   logic [PULSE_BITS-1:0] neu;
   logic [COUNT_BITS-1:0] wait_inc;
   logic [CW-1:0]         wait_cmp;
   logic                  wait_sat;
   logic                  arm_done, delay_done, pause_done;
   logic                  crosses;

   // Step unit signals
   logic                  do_step;
   logic                  step_neu;
   logic [PULSE_BITS-1:0] aim;
   logic [PULSE_BITS-1:0] st;
   logic [PULSE_BITS-1:0] gap;
   logic [PULSE_BITS-1:0] mv;
   logic [PULSE_BITS-1:0] step_nxt;

   assign take       = item_valid && item_ready;
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign neu        = PULSE_BITS'(cfg.neutral_us);

   // Saturating tick count and wait-over tests
   assign wait_inc   = (wait_ff == COUNT_MAX) ? wait_ff : (wait_ff + COUNT_BITS'(1));
   assign wait_cmp   = CW'(wait_inc);
   assign wait_sat   = (wait_inc == COUNT_MAX);
   assign arm_done   = (wait_cmp >= CW'(cfg.arm_ticks)) || wait_sat;
   assign delay_done = (wait_cmp >= CW'(cfg.delay_ticks)) || wait_sat;
   assign pause_done = (wait_cmp >= CW'(cfg.pause_ticks)) || wait_sat;

   // Goal on the far side of neutral from the present pulse
   assign crosses = ((pulse_ff < neu) && (item_tgt > neu)) ||
                    ((pulse_ff > neu) && (item_tgt < neu));

   // Next state for one word
   always_comb begin
      pulse_in = pulse_ff;
      goal_in  = goal_ff;
      mode_in  = mode_ff;
      wait_in  = wait_ff;
      took     = 1'b0;
      do_step  = 1'b0;
      step_neu = 1'b0;

      case (item_cmd)
         CMD_TICK: begin
            case (mode_ff)
               PH_ARMING: begin
                  pulse_in = neu;
                  wait_in  = wait_inc;
                  if (arm_done) begin
                     mode_in = PH_HOLDING;
                     wait_in = '0;
                  end
               end
               PH_TO_NEUTRAL, PH_TO_TARGET: begin
                  wait_in = wait_inc;
                  if (delay_done) begin
                     do_step  = 1'b1;
                     step_neu = (mode_ff == PH_TO_NEUTRAL);
                  end
               end
               PH_PAUSING: begin
                  wait_in = wait_inc;
                  if (pause_done) begin
                     wait_in = '0;
                     if (pulse_ff == goal_ff) begin
                        mode_in = PH_HOLDING;
                     end else begin
                        do_step = 1'b1;
                     end
                  end
               end
               default: begin
                  wait_in = wait_ff;
               end
            endcase
         end
         CMD_ARM: begin
            pulse_in = neu;
            goal_in  = neu;
            wait_in  = '0;
            mode_in  = (cfg.arm_ticks == 16'd0) ? PH_HOLDING : PH_ARMING;
         end
         CMD_THROTTLE: begin
            if ((mode_ff != PH_UNARMED) && (mode_ff != PH_ARMING)) begin
               took    = 1'b1;
               goal_in = item_tgt;
               // A pause runs on unless the new goal is neutral
               if (!((mode_ff == PH_PAUSING) && (item_tgt != neu))) begin
                  wait_in = '0;
                  if (crosses) begin
                     do_step  = 1'b1;
                     step_neu = 1'b1;
                  end else if (pulse_ff == item_tgt) begin
                     mode_in = PH_HOLDING;
                  end else begin
                     do_step = 1'b1;
                  end
               end
            end
         end
         default: begin
            took = 1'b0;
         end
      endcase

      // One ramp step toward neutral or the goal, at most step_us (zero counts as one)
      aim = step_neu ? neu : goal_in;
      st  = (cfg.step_us == 8'd0) ? PULSE_BITS'(1) : PULSE_BITS'(cfg.step_us);
      gap = (pulse_ff < aim) ? (aim - pulse_ff) : (pulse_ff - aim);
      mv  = (gap > st) ? st : gap;
      step_nxt = (pulse_ff < aim) ? (pulse_ff + mv) : (pulse_ff - mv);

      if (do_step) begin
         pulse_in = step_nxt;
         wait_in  = '0;
         if (step_nxt == aim) begin
            mode_in = step_neu ? PH_PAUSING : PH_HOLDING;
         end else begin
            mode_in = step_neu ? PH_TO_NEUTRAL : PH_TO_TARGET;
         end
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff <= PULSE_BITS'(NEUTRAL_RESET);
         goal_ff  <= PULSE_BITS'(NEUTRAL_RESET);
         mode_ff  <= PH_UNARMED;
         wait_ff  <= '0;
      end else if (take) begin
         pulse_ff <= pulse_in;
         goal_ff  <= goal_in;
         mode_ff  <= mode_in;
         wait_ff  <= wait_in;
      end
   end

   // Result register
   assign rsp_valid_in = take ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_pulse_ff <= pulse_in;
         rsp_phase_ff <= mode_in;
         rsp_acc_ff   <= took;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pulse_us = rsp_pulse_ff;
   assign rsp_phase    = rsp_phase_ff;
   assign rsp_accepted = rsp_acc_ff;

   // A throttle word is only taken once armed
   a_acc_armed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |->
         (rsp_phase_ff != PH_UNARMED) && (rsp_phase_ff != PH_ARMING))
      else $error("throttle taken while unarmed or arming");

   // The phase moves only when a word is taken
   a_mode_hold: assert property (@(posedge clock) disable iff (reset)
      (!take) |=> $stable(mode_ff))
      else $error("phase changed without a word");

   // Holding and unarmed never carry a running wait
   a_wait_idle: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == PH_HOLDING) || (mode_ff == PH_UNARMED)) |-> (wait_ff == '0))
      else $error("wait count running while idle");

   // A taken throttle word becomes the goal
   a_goal_load: assert property (@(posedge clock) disable iff (reset)
      (take && took) |=> (goal_ff == $past(item_tgt)))
      else $error("goal not loaded from throttle word");

endmodule

`default_nettype wire

// File: src/esc_throttle_pulse_ramp_unit.sv
// Top level of the ESC throttle pulse ramp: register file, goal pipeline and controller.
//
//  channel  | handshake               | words
//  ---------+-------------------------+--------------------------------------------
//  req      | req_valid / req_ready   | req_command, req_direction, req_speed_pct
//  rsp      | rsp_valid / rsp_ready   | rsp_pulse_us, rsp_phase, rsp_accepted
//  csr      | psel / penable / pready | paddr, pwrite, pwdata, prdata
//
// One word per cycle while the result side takes results; the word passes five registers:
// input register, offset multiply, divide-by-100 reciprocal multiply, goal saturation,
// then the controller state and result register, which update together.
// Reset is synchronous and clears state at once (pulse and goal to 1500, unarmed).
// A stalled result holds the pipeline only as far as it is full; bubbles still fill.
`default_nettype none

module esc_throttle_pulse_ramp_unit
   import esc_tpr_pkg::*;
#(
   parameter int PULSE_BITS = PULSE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_command,
   input  wire logic signed [1:0]     req_direction,
   input  wire logic [7:0]            req_speed_pct,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [PULSE_BITS-1:0]      rsp_pulse_us,
   output logic [2:0]                 rsp_phase,
   output logic                       rsp_accepted,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [4:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   cfg_type               cfg;
   logic                  item_valid;
   logic                  item_ready;
   logic [1:0]            item_cmd;
   logic [PULSE_BITS-1:0] item_tgt;

   esc_tpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   esc_tpr_tgt #(
      .PULSE_BITS (PULSE_BITS)
   ) u_tgt (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_direction (req_direction),
      .req_speed_pct (req_speed_pct),
      .item_valid    (item_valid),
      .item_ready    (item_ready),
      .item_cmd      (item_cmd),
      .item_tgt      (item_tgt)
   );

   esc_tpr_core #(
      .PULSE_BITS (PULSE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item_valid   (item_valid),
      .item_ready   (item_ready),
      .item_cmd     (item_cmd),
      .item_tgt     (item_tgt),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_pulse_us (rsp_pulse_us),
      .rsp_phase    (rsp_phase),
      .rsp_accepted (rsp_accepted)
   );

endmodule

`default_nettype wire

// File: bench/esc_tpr_tracker_pkg.sv
// Scoreboard class: predicts the ESC pulse ramp word by word and checks the result words.
package esc_tpr_tracker_pkg;
   import esc_tpr_pkg::*;

   localparam int unsigned PULSE_TOP = (1 << PULSE_BITS_DEF) - 1;
   localparam int unsigned COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;

   // One predicted result word
   typedef struct {
      int unsigned pulse_us;
      phase_type   phase;
      bit          accepted;
   } ramp_word_type;

   class pulse_ramp_tracker_type;
      cfg_type       cfg;
      int unsigned   pulse_now;
      int unsigned   goal_pulse;
      int unsigned   wait_cnt;
      phase_type     mode;
      ramp_word_type due_words[$];
      int unsigned   fail_count;

      // State and registers as they come out of reset
      function void reset_state();
         cfg.neutral_us    = NEUTRAL_RESET;
         cfg.max_offset_us = MAX_OFFSET_RESET;
         cfg.step_us       = STEP_RESET;
         cfg.delay_ticks   = DELAY_RESET;
         cfg.pause_ticks   = PAUSE_RESET;
         cfg.arm_ticks     = ARM_RESET;
         pulse_now  = NEUTRAL_RESET;
         goal_pulse = NEUTRAL_RESET;
         mode       = PH_UNARMED;
         wait_cnt   = 0;
         fail_count = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_NEUTRAL:    cfg.neutral_us    = val[11:0];
            REG_MAX_OFFSET: cfg.max_offset_us = val[10:0];
            REG_STEP:       cfg.step_us       = val[7:0];
            REG_DELAY:      cfg.delay_ticks   = val[7:0];
            REG_PAUSE:      cfg.pause_ticks   = val[15:0];
            REG_ARM:        cfg.arm_ticks     = val[15:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_NEUTRAL:    return 32'(cfg.neutral_us);
            REG_MAX_OFFSET: return 32'(cfg.max_offset_us);
            REG_STEP:       return 32'(cfg.step_us);
            REG_DELAY:      return 32'(cfg.delay_ticks);
            REG_PAUSE:      return 32'(cfg.pause_ticks);
            REG_ARM:        return 32'(cfg.arm_ticks);
            default:        return 32'd0;
         endcase
      endfunction

      // Count one tick; true once the wait is over (or the counter is pinned)
      function bit wait_done(int unsigned lim);
         if (wait_cnt < COUNT_TOP) begin
            wait_cnt++;
         end
         return wait_cnt >= lim || wait_cnt == COUNT_TOP;
      endfunction

      // Move the pulse by at most one step toward aim; true when it lands
      function bit move_toward(int unsigned aim);
         int unsigned stride;
         int unsigned gap;
         stride = (cfg.step_us == 0) ? 1 : cfg.step_us;
         if (pulse_now < aim) begin
            gap = aim - pulse_now;
            pulse_now += (gap > stride) ? stride : gap;
         end else begin
            gap = pulse_now - aim;
            pulse_now -= (gap > stride) ? stride : gap;
         end
         wait_cnt = 0;
         return pulse_now == aim;
      endfunction

      function void ramp_once();
         if (mode == PH_TO_NEUTRAL) begin
            if (move_toward(cfg.neutral_us)) begin
               mode = PH_PAUSING;
            end
         end else if (mode == PH_TO_TARGET) begin
            if (move_toward(goal_pulse)) begin
               mode = PH_HOLDING;
            end
         end
      endfunction

      // Goal pulse for a throttle word, saturated to the pulse range
      function int unsigned goal_for(logic [1:0] dir, logic [7:0] spd);
         int unsigned pct;
         int unsigned offset;
         int unsigned sum;
         pct = (spd > FULL_PCT) ? FULL_PCT : spd;
         offset = (cfg.max_offset_us * pct) / FULL_PCT;
         if (pct == 0) begin
            return cfg.neutral_us;
         end
         if (dir == 2'b01) begin
            sum = cfg.neutral_us + offset;
            return (sum > PULSE_TOP) ? PULSE_TOP : sum;
         end
         if (dir[1]) begin
            return (offset > cfg.neutral_us) ? 0 : cfg.neutral_us - offset;
         end
         return cfg.neutral_us;
      endfunction

      function void apply_throttle(logic [1:0] dir, logic [7:0] spd);
         int unsigned aim;
         bit crosses;
         aim = goal_for(dir, spd);
         crosses = (pulse_now < cfg.neutral_us && aim > cfg.neutral_us) ||
                   (pulse_now > cfg.neutral_us && aim < cfg.neutral_us);
         goal_pulse = aim;
         // pause keeps running unless the new goal is neutral
         if (mode == PH_PAUSING && aim != cfg.neutral_us) begin
            return;
         end
         wait_cnt = 0;
         if (crosses) begin
            mode = PH_TO_NEUTRAL;
            ramp_once();
         end else if (pulse_now == aim) begin
            mode = PH_HOLDING;
         end else begin
            mode = PH_TO_TARGET;
            ramp_once();
         end
      endfunction

      // Note an accepted input word and queue the result it must produce
      function void take_request(logic [1:0] cmd, logic [1:0] dir, logic [7:0] spd);
         bit took;
         ramp_word_type w;
         took = 0;
         case (cmd)
            CMD_TICK: begin
               if (mode == PH_ARMING) begin
                  pulse_now = cfg.neutral_us;
                  if (wait_done(cfg.arm_ticks)) begin
                     mode = PH_HOLDING;
                     wait_cnt = 0;
                  end
               end else if (mode == PH_TO_NEUTRAL || mode == PH_TO_TARGET) begin
                  if (wait_done(cfg.delay_ticks)) begin
                     ramp_once();
                  end
               end else if (mode == PH_PAUSING) begin
                  if (wait_done(cfg.pause_ticks)) begin
                     mode = PH_TO_TARGET;
                     wait_cnt = 0;
                     if (pulse_now == goal_pulse) begin
                        mode = PH_HOLDING;
                     end else begin
                        ramp_once();
                     end
                  end
               end
            end
            CMD_ARM: begin
               pulse_now  = cfg.neutral_us;
               goal_pulse = cfg.neutral_us;
               wait_cnt   = 0;
               mode = (cfg.arm_ticks == 0) ? PH_HOLDING : PH_ARMING;
            end
            CMD_THROTTLE: begin
               if (mode >= PH_HOLDING && mode <= PH_TO_TARGET) begin
                  apply_throttle(dir, spd);
                  took = 1;
               end
            end
            default: ;
         endcase
         w.pulse_us = pulse_now & PULSE_TOP;
         w.phase    = mode;
         w.accepted = took;
         due_words.push_back(w);
      endfunction

      // Compare a result word with the oldest prediction
      function void check_reply(logic [11:0] pulse, logic [2:0] phase, logic acc);
         ramp_word_type w;
         if (due_words.size() == 0) begin
            $error("unexpected result word: pulse_us %0d phase %0d accepted %0d",
                   pulse, phase, acc);
            fail_count++;
            return;
         end
         w = due_words.pop_front();
         if (pulse !== w.pulse_us[11:0]) begin
            $error("pulse_us: expected %0d, actual %0d", w.pulse_us, pulse);
            fail_count++;
         end
         if (phase !== w.phase) begin
            $error("phase: expected %0d, actual %0d", w.phase, phase);
            fail_count++;
         end
         if (acc !== w.accepted) begin
            $error("accepted: expected %0d, actual %0d", w.accepted, acc);
            fail_count++;
         end
      endfunction
   endclass

endpackage

// File: bench/tb.sv
// Testbench top: drives words and register writes into the ESC pulse ramp and checks results.
module tb
   import esc_tpr_pkg::*;
   import esc_tpr_tracker_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [1:0] DIR_STOP    = 2'b00;
   localparam logic [1:0] DIR_FWD     = 2'b01;
   localparam logic [1:0] DIR_REV     = 2'b11;
   localparam logic [1:0] DIR_REV_ALT = 2'b10;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_command;
   logic signed [1:0]  req_direction;
   logic [7:0]         req_speed_pct;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [11:0]        rsp_pulse_us;
   logic [2:0]         rsp_phase;
   logic               rsp_accepted;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [4:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   pulse_ramp_tracker_type tracker;
   bit                     calm;
   int                     stall_left;

   esc_throttle_pulse_ramp_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_direction (req_direction),
      .req_speed_pct (req_speed_pct),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pulse_us  (rsp_pulse_us),
      .rsp_phase     (rsp_phase),
      .rsp_accepted  (rsp_accepted),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Send one word; may idle a short burst first
   task automatic send_word(logic [1:0] cmd, logic [1:0] dir, logic [7:0] spd);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid = 1'b0;
         req_command = 2'($urandom);
         req_direction = 2'($urandom);
         req_speed_pct = 8'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_command   = cmd;
      req_direction = dir;
      req_speed_pct = spd;
      do @(posedge clock); while (!req_ready);
      tracker.take_request(cmd, dir, spd);
   endtask

   // Drop valid and wait until every predicted word has come back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.due_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = val;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      tracker.write_reg(idx, val);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Read back every register and compare with the tracked copy
   task automatic check_regs();
      logic [31:0] want;
      for (int i = REG_NEUTRAL; i <= REG_ARM; i++) begin
         @(negedge clock);
         psel    = 1'b1;
         penable = 1'b0;
         pwrite  = 1'b0;
         paddr   = {3'(i), 2'b00};
         @(negedge clock);
         penable = 1'b1;
         do @(posedge clock); while (!pready);
         want = tracker.reg_value(3'(i));
         if (prdata !== want) begin
            $error("register %0d: expected %0d, actual %0d", i, want, prdata);
            tracker.fail_count++;
         end
         @(negedge clock);
         psel    = 1'b0;
         penable = 1'b0;
      end
   endtask

   task automatic load_setting(cfg_type c);
      csr_write(REG_NEUTRAL,    32'(c.neutral_us));
      csr_write(REG_MAX_OFFSET, 32'(c.max_offset_us));
      csr_write(REG_STEP,       32'(c.step_us));
      csr_write(REG_DELAY,      32'(c.delay_ticks));
      csr_write(REG_PAUSE,      32'(c.pause_ticks));
      csr_write(REG_ARM,        32'(c.arm_ticks));
      check_regs();
   endtask

   // Arm, then a random mix dominated by ticks and throttle words
   task automatic run_mix(int count);
      int r;
      int s;
      logic [7:0] spd;
      send_word(CMD_ARM, 2'($urandom), 8'($urandom));
      for (int n = 1; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            send_word(CMD_UNUSED, 2'($urandom), 8'($urandom));
         end else if (r < 5) begin
            send_word(CMD_ARM, 2'($urandom), 8'($urandom));
         end else if (r < 35) begin
            s = $urandom_range(0, 9);
            if (s == 0) spd = 8'd0;
            else if (s < 3) spd = 8'd100;
            else if (s < 5) spd = 8'($urandom_range(101, 255));
            else spd = 8'($urandom_range(0, 100));
            send_word(CMD_THROTTLE, 2'($urandom_range(0, 3)), spd);
         end else begin
            send_word(CMD_TICK, 2'($urandom), 8'($urandom));
         end
      end
      drain();
   endtask

   // Random setting with short waits so ramps and pauses complete often
   function automatic cfg_type mixed_setting();
      cfg_type c;
      c.neutral_us    = 12'($urandom_range(0, 4095));
      c.max_offset_us = 11'($urandom_range(0, 2047));
      c.step_us       = 8'($urandom_range(0, 60));
      c.delay_ticks   = 8'($urandom_range(0, 6));
      c.pause_ticks   = 16'($urandom_range(0, 20));
      c.arm_ticks     = 16'($urandom_range(0, 10));
      return c;
   endfunction

   // Result side: random ready bursts, checked at the rising edge
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready = 1'b0;
         end else if (!calm && !reset && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reply(rsp_pulse_us, rsp_phase, rsp_accepted);
      end
   end

   // Main sequence
   initial begin
      tracker = new;
      tracker.reset_state();
      calm          = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_TICK;
      req_direction = DIR_STOP;
      req_speed_pct = 8'd0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = 5'd0;
      pwdata        = 32'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values, then words ignored before and during arming
      check_regs();
      send_word(CMD_THROTTLE, DIR_FWD, 8'd50);
      send_word(CMD_UNUSED, DIR_REV, 8'd255);
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_ARM, DIR_STOP, 8'd0);
      send_word(CMD_THROTTLE, DIR_FWD, 8'd100);
      drain();

      // directed ramps with a zero step, no delay and a short pause
      load_setting('{neutral_us: 12'd1000, max_offset_us: 11'd2047, step_us: 8'd0,
                     delay_ticks: 8'd0, pause_ticks: 16'd2, arm_ticks: 16'd2});
      send_word(CMD_ARM, DIR_STOP, 8'd0);
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_THROTTLE, DIR_FWD, 8'd255);     // speed clamps to full
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_THROTTLE, DIR_REV, 8'd100);     // crosses neutral, goal floors at 0
      send_word(CMD_TICK, DIR_STOP, 8'd0);          // reaches neutral, starts pause
      send_word(CMD_THROTTLE, DIR_REV_ALT, 8'd30);  // new goal, pause runs on
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_THROTTLE, DIR_FWD, 8'd1);       // crosses back
      send_word(CMD_THROTTLE, DIR_STOP, 8'd80);     // neutral goal while pausing
      send_word(CMD_THROTTLE, DIR_FWD, 8'd0);
      send_word(CMD_THROTTLE, DIR_FWD, 8'd5);
      send_word(CMD_THROTTLE, DIR_REV, 8'd50);      // crosses neutral, lands on it, starts pause
      send_word(CMD_THROTTLE, DIR_FWD, 8'd5);       // new goal, pause runs on
      send_word(CMD_TICK, DIR_STOP, 8'd0);
      send_word(CMD_ARM, DIR_FWD, 8'd0);            // arm in mid pause
      drain();

      load_setting('{neutral_us: 12'd1500, max_offset_us: 11'd450, step_us: 8'd25,
                     delay_ticks: 8'd3, pause_ticks: 16'd30, arm_ticks: 16'd4});
      run_mix(350);
      // top extremes: saturation high, no waits at all
      load_setting('{neutral_us: 12'd4095, max_offset_us: 11'd2047, step_us: 8'd255,
                     delay_ticks: 8'd0, pause_ticks: 16'd0, arm_ticks: 16'd0});
      run_mix(250);
      // bottom extremes: neutral at zero, zero step
      load_setting('{neutral_us: 12'd0, max_offset_us: 11'd1, step_us: 8'd0,
                     delay_ticks: 8'd1, pause_ticks: 16'd1, arm_ticks: 16'd1});
      run_mix(250);
      // longest waits: arming never ends within the phase
      load_setting('{neutral_us: 12'd2048, max_offset_us: 11'd0, step_us: 8'd1,
                     delay_ticks: 8'd255, pause_ticks: 16'd65535, arm_ticks: 16'd65535});
      run_mix(60);
      // large steps spaced far apart
      load_setting('{neutral_us: 12'd100, max_offset_us: 11'd1000, step_us: 8'd255,
                     delay_ticks: 8'd255, pause_ticks: 16'd3, arm_ticks: 16'd2});
      run_mix(150);
      for (int p = 0; p < 3; p++) begin
         load_setting(mixed_setting());
         if (p == 2) calm = 1'b1;
         run_mix(250);
      end

      repeat (20) @(posedge clock);
      if (tracker.fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
